### hdl/base64_stream_encoder_unit_macros.svh
// assertion macros for the base64 stream encoder checker
// no dependencies; the including module must have clk and rst_n in scope
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define B64SE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next clock edge
`define B64SE_ASSERT_NEXT(lbl, ante, cons, msg) \
    `B64SE_ASSERT(lbl, ((ante) |=> (cons)), msg)

`endif

### hdl/b64se_pkg.sv
// shared types and the alphabet lookup for the base64 stream encoder
// no dependencies
package b64se_pkg;

    localparam int unsigned GROUP_CHARS = 4;
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned IDX_W       = $clog2(GROUP_CHARS);

    // pending count codes
    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // index of the last character in a group
    localparam logic [IDX_W-1:0] LAST_OF_TWO   = 2'd1;
    localparam logic [IDX_W-1:0] LAST_OF_THREE = 2'd2;
    localparam logic [IDX_W-1:0] LAST_OF_FOUR  = 2'd3;

    // one group of sextets handed from the collector to the serializer
    typedef struct packed {
        logic                                emit;
        logic [GROUP_CHARS-1:0][SEXTET_W-1:0] sext;
        logic [IDX_W-1:0]                    last_idx;
    } grp_t;

    // serializer status seen by the top level
    typedef struct packed {
        logic busy;
        logic last_take;
    } ser_stat_t;

    // sextet to ASCII from the standard alphabet
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        logic [CHAR_W-1:0] w;
        logic [CHAR_W-1:0] c;
        w = CHAR_W'(v);
        if (v < 6'd26)
            c = 8'h41 + w;
        else if (v < 6'd52)
            c = 8'h61 + (w - 8'd26);
        else if (v < 6'd62)
            c = 8'h30 + (w - 8'd52);
        else if (v == 6'd62)
            c = 8'h2b;
        else
            c = 8'h2f;
        return c;
    endfunction

endpackage

### hdl/b64se_collect.sv
// byte collector: pending bytes, pending count and sextet formation
// depends on b64se_pkg
module b64se_collect
    import b64se_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output grp_t       grp
);

    logic [7:0] pend0_reg;
    logic [7:0] pend1_reg;
    logic [1:0] cnt_reg;
    logic [7:0] pend0_next;
    logic [7:0] pend1_next;
    logic [1:0] cnt_next;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;

    // group assembly and next pending state
    always_comb
    begin
        pend0_next   = pend0_reg;
        pend1_next   = pend1_reg;
        cnt_next     = cnt_reg;
        b0           = pend0_reg;
        b1           = pend1_reg;
        b2           = data_byte;
        grp.emit     = 1'b0;
        grp.last_idx = LAST_OF_FOUR;
        unique case (cnt_reg) inside
            CNT_TWO, CNT_THREE:
            begin
                grp.emit = 1'b1;
                cnt_next = CNT_EMPTY;
            end
            CNT_ONE:
            begin
                b1 = data_byte;
                b2 = 8'h00;
                if (final_byte)
                begin
                    grp.emit     = 1'b1;
                    grp.last_idx = LAST_OF_THREE;
                    cnt_next     = CNT_EMPTY;
                end
                else
                begin
                    pend1_next = data_byte;
                    cnt_next   = CNT_TWO;
                end
            end
            default:
            begin
                b0 = data_byte;
                b1 = 8'h00;
                b2 = 8'h00;
                if (final_byte)
                begin
                    grp.emit     = 1'b1;
                    grp.last_idx = LAST_OF_TWO;
                end
                else
                begin
                    pend0_next = data_byte;
                    cnt_next   = CNT_ONE;
                end
            end
        endcase

        // split three bytes into four sextets, msb first
        grp.sext[0] = b0[7:2];
        grp.sext[1] = {b0[1:0], b1[7:4]};
        grp.sext[2] = {b1[3:0], b2[7:6]};
        grp.sext[3] = b2[5:0];
    end

    // pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= CNT_EMPTY;
        else if (accept)
            cnt_reg <= cnt_next;
    end

    // pending bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= 8'h00;
            pend1_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
        end
    end

endmodule

### hdl/b64se_serial.sv
// group buffer and character serializer, one character per request
// depends on b64se_pkg
module b64se_serial
    import b64se_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  grp_t        grp,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  out_char,
    output logic        run_end,
    output ser_stat_t   stat
);

    logic                                 valid_reg;
    logic [GROUP_CHARS-1:0][SEXTET_W-1:0] sext_reg;
    logic [IDX_W-1:0]                     idx_reg;
    logic [IDX_W-1:0]                     last_reg;
    logic                                 at_last;
    logic                                 take;

    assign at_last        = (idx_reg == last_reg);
    assign take           = valid_reg && !out_stall;
    assign stat.busy      = valid_reg;
    assign stat.last_take = take && at_last;

    // output from the buffered group
    assign out_valid = valid_reg;
    assign out_char  = sextet_char(sext_reg[idx_reg]);
    assign run_end   = at_last;

    // buffer occupancy and character index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (stat.last_take)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sext_reg <= grp.sext;
            last_reg <= grp.last_idx;
        end
    end

endmodule

### hdl/base64_stream_encoder_unit.sv
// top level of the unpadded base64 stream encoder
// depends on b64se_pkg, b64se_collect, b64se_serial
//
// channel | direction | fields                 | handshake
// --------+-----------+------------------------+---------------------
// in      | input     | data_byte, final_byte  | in_valid / in_stall
// out     | output    | out_char, run_end      | out_valid / out_stall
//
// a byte that completes or ends a group loads the group buffer, which then
// sends 2 to 4 characters, one per cycle while out_stall is low. bytes
// that emit nothing pass even while the buffer drains, so throughput is
// set by the one-character output port.
// reset clears the pending count and empties the group buffer.
// an emitting byte is stalled until the buffer is empty or its last
// character is being taken.
module base64_stream_encoder_unit
    import b64se_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_end
);

    grp_t      grp;
    ser_stat_t stat;
    logic      accept;

    // input request flow
    assign in_stall = grp.emit && stat.busy && !stat.last_take;
    assign accept   = in_valid && !in_stall;

    b64se_collect u_collect (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .grp        (grp)
    );

    b64se_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && grp.emit),
        .grp       (grp),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_char  (out_char),
        .run_end   (run_end),
        .stat      (stat)
    );

endmodule

### hdl/b64se_checker.sv
// port-level checks for the base64 stream encoder, bound to the top level
// depends on base64_stream_encoder_unit_macros.svh
`include "base64_stream_encoder_unit_macros.svh"

module b64se_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       final_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       run_end
);

    // a stalled request holds
    `B64SE_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable({data_byte, final_byte}), "stalled request changed")

    // a stalled character holds
    `B64SE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(run_end), "stalled output changed")

    // output only starts after an accepted request
    `B64SE_ASSERT(a_out_cause, ($rose(out_valid) |-> $past(in_valid && !in_stall)), "output without request")

    // the last byte of a message always produces characters
    `B64SE_ASSERT_NEXT(a_final_emits, in_valid && !in_stall && final_byte, out_valid, "final byte gave no output")

    // characters of one run come without gaps
    `B64SE_ASSERT_NEXT(a_run_gapless, out_valid && !out_stall && !run_end, out_valid, "gap inside a run")

endmodule

bind base64_stream_encoder_unit b64se_checker u_b64se_checker (.*);

### verif/tb_top.sv
// self-checking bench for the unpadded base64 stream encoder
// depends on b64se_pkg and base64_stream_encoder_unit; predicts every character
// from the accepted bytes and checks results in order under random stalls
module tb_top;
    import b64se_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 90;

    // one expected output character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } b64_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       run_end;

    string      b64_alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                "abcdefghijklmnopqrstuvwxyz", "0123456789+/"};

    // predictor state
    logic [7:0] group_bytes [2];
    logic [1:0] group_count;
    b64_char_t  expected_chars [$];

    int         errors = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_req = 0;
    int         hold_left = 0;

    base64_stream_encoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .run_end    (run_end)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // queue the first n characters of the group b0 b1 b2
    task automatic push_group(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input int n);
        logic [5:0] sx [4];
        b64_char_t  c;
        sx[0] = b0[7:2];
        sx[1] = {b0[1:0], b1[7:4]};
        sx[2] = {b1[3:0], b2[7:6]};
        sx[3] = b2[5:0];
        for (int k = 0; k < n; k++)
        begin
            c.ch      = b64_alphabet[int'(sx[k])];
            c.is_last = (k == n - 1);
            expected_chars = {expected_chars, c};
        end
    endtask

    // advance the encoder prediction by one accepted byte
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [1:0] cnt;
        cnt = (group_count == CNT_THREE) ? CNT_TWO : group_count;
        if (cnt == CNT_TWO)
        begin
            push_group(group_bytes[0], group_bytes[1], b, 4);
            group_bytes[0] = 8'h00;
            group_bytes[1] = 8'h00;
            group_count    = CNT_EMPTY;
        end
        else
        begin
            group_bytes[cnt[0]] = b;
            cnt = cnt + 2'd1;
            if (!fin)
                group_count = cnt;
            else
            begin
                // partial group at end of message, zero filled
                if (cnt == CNT_ONE)
                    push_group(group_bytes[0], 8'h00, 8'h00, 2);
                else
                    push_group(group_bytes[0], group_bytes[1], 8'h00, 3);
                group_bytes[0] = 8'h00;
                group_bytes[1] = 8'h00;
                group_count    = CNT_EMPTY;
            end
        end
    endtask

    // predict on accepted requests, then check accepted characters
    always @(posedge clk or negedge rst_n)
    begin
        b64_char_t exp_c;
        if (!rst_n)
        begin
            group_bytes[0] = 8'h00;
            group_bytes[1] = 8'h00;
            group_count    = CNT_EMPTY;
        end
        else
        begin
            if (in_valid && !in_stall)
                encode_byte(data_byte, final_byte);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character %02h run_end %0b",
                             $time, out_char, run_end);
                    errors++;
                end
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (out_char !== exp_c.ch)
                    begin
                        $display("%0t: out_char expected %02h got %02h",
                                 $time, exp_c.ch, out_char);
                        errors++;
                    end
                    if (run_end !== exp_c.is_last)
                    begin
                        $display("%0t: run_end expected %0b got %0b",
                                 $time, exp_c.is_last, run_end);
                        errors++;
                    end
                end
            end
        end
    end

    // output stall: random, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // offer one byte and wait until it is taken
    task automatic send_byte(input logic [7:0] d, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // alphabet extremes, partial and full groups, group completed by the last byte
    task automatic test_directed();
        logic [8:0] seq [22];
        seq = '{{1'b1, 8'h00},
                {1'b1, 8'hff},
                {1'b0, 8'hff}, {1'b1, 8'hff},
                {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00},
                {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b1, 8'hff},
                {1'b0, 8'h4d}, {1'b0, 8'h61}, {1'b0, 8'h6e}, {1'b1, 8'h4d},
                {1'b0, 8'hfb}, {1'b0, 8'hef}, {1'b1, 8'hbe},
                {1'b0, 8'h55}, {1'b0, 8'haa}, {1'b0, 8'h55}, {1'b0, 8'haa},
                {1'b1, 8'h55}};
        foreach (seq[i])
            send_byte(seq[i][7:0], seq[i][8]);
    endtask

    // whole messages of random length and content, mostly short
    task automatic test_random_messages(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(255)), i == len - 1);
            sent += len;
        end
    endtask

    // long output hold while bytes keep coming, so the input backs up
    task automatic test_output_hold();
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom_range(255)), i == 15);
    endtask

    // sender goes quiet until every character is out, then resumes
    task automatic test_drain_pause();
        stop_sending();
        wait_drained();
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom_range(255)), i == 4);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender rarely idle, receiver mostly stalled
        tx_idle_pct = 8;
        rx_idle_pct = 83;
        test_directed();
        test_random_messages(35);
        test_output_hold();

        // sender mostly idle, receiver rarely stalled
        tx_idle_pct = 83;
        rx_idle_pct = 8;
        test_random_messages(35);
        test_drain_pause();

        // full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_messages(35);

        stop_sending();
        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0 && expected_chars.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
